// ----- rtl/core/lfo_shaped_phase_output_macros.svh -----
// ----------------------------------------------------------------------------
// lfo_shaped_phase_output_macros.svh
// Assertion shorthands used by the oscillator checker.
// ----------------------------------------------------------------------------
`ifndef LFO_SHAPED_PHASE_OUTPUT_MACROS_SVH
`define LFO_SHAPED_PHASE_OUTPUT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define LSPO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define LSPO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lspo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspo_pkg
// Commands, register map and waveform shaping for the shaped-phase LFO.
// ----------------------------------------------------------------------------
package lspo_pkg;

  localparam int unsigned PhaseW = 16;
  localparam int unsigned LevelW = 8;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // Input commands
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_SET  = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_INCREMENT = 3'd0;
  localparam logic [2:0] REG_SKIP      = 3'd1;
  localparam logic [2:0] REG_WAVEFORM  = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_THR_MODE  = 3'd4;
  localparam logic [2:0] REG_XOR_MASK  = 3'd5;
  localparam logic [2:0] REG_FLOP_MASK = 3'd6;

  localparam logic WAVE_SAW   = 1'b0;
  localparam logic MODE_FOLD  = 1'b0;

  // Saw passes the step; triangle rises 0..254 then falls back.
  function automatic logic [LevelW-1:0] shape_level(input logic [LevelW-1:0] step,
                                                    input logic            wave);
    logic [LevelW:0] fall;
    fall = 9'd510 - {step, 1'b0};
    if (wave == WAVE_SAW) begin
      return step;
    end else if (!step[LevelW-1]) begin
      return {step[LevelW-2:0], 1'b0};
    end else begin
      return fall[LevelW-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/lfo_shaped_phase_output.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_shaped_phase_output
// Phase-accumulator LFO with resolution hold, saw/triangle shaping,
// threshold wrap/fold and output XOR, built around one shared 16-bit adder.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+-------------------------
//  in      | in        | in_valid_i / in_stall_o   | command_i, step_value_i
//  out     | out       | out_valid_o / out_stall_i | level_o
//  cfg     | in        | APB psel/penable/pready   | paddr, pwdata, prdata
//
//  Steps: tick and set are accepted, then dispatched. A read is accepted,
//  dispatched and output when flopped; held adds the hold test; a fresh
//  level within the threshold adds the marker step; the modulo adds
//  S_DIV and S_FOLD: the shared adder does one restoring-division bit per cycle.
//  Reset: rst_ni async low; phase, marker and held level clear, threshold
//  resets to 255, other registers to 0.
//  Stalls: the result word sits in the output register until taken; no new
//  input word is accepted until then.
//
module lfo_shaped_phase_output (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      command_i,
  input  logic [lspo_pkg::LevelW-1:0]     step_value_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lspo_pkg::LevelW-1:0]     level_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lspo_pkg::AddrW-1:0]      paddr,
  input  logic [lspo_pkg::DataW-1:0]      pwdata,
  output logic [lspo_pkg::DataW-1:0]      prdata,
  output logic                            pready
);
  import lspo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,   // tick/set finish here; read does flop test and phase - marker
    S_HOLD,       // since - skip_count: borrow means hold
    S_MARK,       // marker += skip_count, shape, decide on modulo
    S_DIV,        // one quotient bit per cycle
    S_FOLD,       // fold/wrap pick, XOR, store
    S_OUT
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [PhaseW-1:0] inc_q, skip_q;
  logic              wave_q, mode_q;
  logic [LevelW-1:0] thr_q, xor_q, flop_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q  <= '0;
      skip_q <= '0;
      wave_q <= 1'b0;
      thr_q  <= '1;
      mode_q <= 1'b0;
      xor_q  <= '0;
      flop_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[AddrW-1:2])
        REG_INCREMENT: inc_q  <= pwdata[PhaseW-1:0];
        REG_SKIP:      skip_q <= pwdata[PhaseW-1:0];
        REG_WAVEFORM:  wave_q <= pwdata[0];
        REG_THRESHOLD: thr_q  <= pwdata[LevelW-1:0];
        REG_THR_MODE:  mode_q <= pwdata[0];
        REG_XOR_MASK:  xor_q  <= pwdata[LevelW-1:0];
        REG_FLOP_MASK: flop_q <= pwdata[LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[AddrW-1:2])
      REG_INCREMENT: prdata = {{(DataW-PhaseW){1'b0}}, inc_q};
      REG_SKIP:      prdata = {{(DataW-PhaseW){1'b0}}, skip_q};
      REG_WAVEFORM:  prdata = {{(DataW-1){1'b0}}, wave_q};
      REG_THRESHOLD: prdata = {{(DataW-LevelW){1'b0}}, thr_q};
      REG_THR_MODE:  prdata = {{(DataW-1){1'b0}}, mode_q};
      REG_XOR_MASK:  prdata = {{(DataW-LevelW){1'b0}}, xor_q};
      REG_FLOP_MASK: prdata = {{(DataW-LevelW){1'b0}}, flop_q};
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // --------------------------------------------------------------------------
  state_e            state_q;
  logic [1:0]        cmd_q;
  logic [LevelW-1:0] stepv_q;
  logic [PhaseW-1:0] phase_q, marker_q, since_q;
  logic [LevelW-1:0] held_q, level_q;
  logic [LevelW-1:0] rem_q;   // partial remainder
  logic [LevelW-1:0] dvd_q;   // dividend shifts out, quotient shifts in
  logic [2:0]        cnt_q;

  // --------------------------------------------------------------------------
  // Shared adder/subtractor: y = a + b or a - b, y[PhaseW] is carry-out
  // (for subtract, carry-out low means a borrow, i.e. a < b).
  // --------------------------------------------------------------------------
  logic [PhaseW-1:0] alu_a, alu_b;
  logic              alu_sub;
  logic [PhaseW:0]   alu_y;
  logic              alu_borrow;
  logic [LevelW:0]   div_shift;

  assign div_shift = {rem_q, dvd_q[LevelW-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_DISPATCH: begin
        alu_a   = phase_q;
        alu_b   = (cmd_q == CMD_TICK) ? inc_q : marker_q;
        alu_sub = (cmd_q != CMD_TICK);
      end
      S_HOLD: begin
        alu_a   = since_q;
        alu_b   = skip_q;
        alu_sub = 1'b1;
      end
      S_MARK: begin
        alu_a   = marker_q;
        alu_b   = skip_q;
      end
      S_DIV: begin
        alu_a   = {{(PhaseW-LevelW-1){1'b0}}, div_shift};
        alu_b   = {{(PhaseW-LevelW){1'b0}}, thr_q};
        alu_sub = 1'b1;
      end
      S_FOLD: begin
        alu_a   = {{(PhaseW-LevelW){1'b0}}, thr_q};
        alu_b   = {{(PhaseW-LevelW){1'b0}}, rem_q};
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign alu_y      = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                    + {{PhaseW{1'b0}}, alu_sub};
  assign alu_borrow = alu_sub && !alu_y[PhaseW];

  // Shaped level from the current step, before threshold handling
  logic [LevelW-1:0] shaped;
  logic              fold_odd;
  logic [LevelW-1:0] fold_val;

  assign shaped   = shape_level(phase_q[PhaseW-1 -: LevelW], wave_q);
  // dvd_q holds the quotient by the time S_FOLD runs
  assign fold_odd = (mode_q == MODE_FOLD) && dvd_q[0];
  assign fold_val = fold_odd ? alu_y[LevelW-1:0] : rem_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign level_o     = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= CMD_TICK;
      stepv_q  <= '0;
      phase_q  <= '0;
      marker_q <= '0;
      since_q  <= '0;
      held_q   <= '0;
      level_q  <= '0;
      rem_q    <= '0;
      dvd_q    <= '0;
      cnt_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= command_i;
            stepv_q <= step_value_i;
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          since_q <= alu_y[PhaseW-1:0];
          case (cmd_q)
            CMD_TICK: begin
              phase_q <= alu_y[PhaseW-1:0];
              state_q <= S_IDLE;
            end
            CMD_SET: begin
              phase_q <= {stepv_q, {(PhaseW-LevelW){1'b0}}};
              state_q <= S_IDLE;
            end
            CMD_READ: begin
              // any flop-masked step bit forces zero, state untouched
              if ((phase_q[PhaseW-1 -: LevelW] & flop_q) != '0) begin
                level_q <= '0;
                state_q <= S_OUT;
              end else begin
                state_q <= S_HOLD;
              end
            end
            default: state_q <= S_IDLE;  // unused command: no result
          endcase
        end
        S_HOLD: begin
          if (alu_borrow) begin
            level_q <= held_q;
            state_q <= S_OUT;
          end else begin
            state_q <= S_MARK;
          end
        end
        S_MARK: begin
          marker_q <= alu_y[PhaseW-1:0];
          if (shaped > thr_q && thr_q != '0) begin
            dvd_q   <= shaped;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end else begin
            // within threshold, or zero threshold forcing 0
            level_q <= ((shaped > thr_q) ? '0 : shaped) ^ xor_q;
            held_q  <= ((shaped > thr_q) ? '0 : shaped) ^ xor_q;
            state_q <= S_OUT;
          end
        end
        S_DIV: begin
          rem_q <= alu_borrow ? div_shift[LevelW-1:0] : alu_y[LevelW-1:0];
          dvd_q <= {dvd_q[LevelW-2:0], !alu_borrow};
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            state_q <= S_FOLD;
          end
        end
        S_FOLD: begin
          level_q <= fold_val ^ xor_q;
          held_q  <= fold_val ^ xor_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/lspo_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspo_checker
// Port-level checks for the shaped-phase LFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "lfo_shaped_phase_output_macros.svh"

module lspo_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  command_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lspo_pkg::LevelW-1:0] level_o,
  input logic                        pready
);
  import lspo_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  `LSPO_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o, "not busy after accepted word")
  `LSPO_ASSERT_NOW(a_no_accept_with_result, out_valid_o, in_stall_o, "input open with result pending")
  `LSPO_ASSERT_NEXT(a_no_result_for_tick_set, in_acc && (command_i == CMD_TICK || command_i == CMD_SET), !out_valid_o, "result for tick or set")
  `LSPO_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(level_o), "stalled result word changed")
  `LSPO_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

endmodule

bind lfo_shaped_phase_output lspo_checker u_lspo_checker (.*);
